// File: hw/rtl/ewts_pkg.sv
// shared types and constants of the earliest-wakeup task scheduler
package ewts_pkg;

   localparam logic [1:0] OP_CREATE = 2'd0;
   localparam logic [1:0] OP_END    = 2'd1;
   localparam logic [1:0] OP_DELAY  = 2'd2;
   localparam logic [1:0] OP_EXIT   = 2'd3;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_FULL   = 2'd1;
   localparam logic [1:0] ST_NOTASK = 2'd2;

   localparam logic [63:0] WAKE_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [63:0] now;
      logic [31:0] sleep_ticks;
      logic [2:0]  task_index;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [2:0]  slot;
      logic [31:0] delay_ms;
   } rsp_type;

   typedef struct packed {
      logic [63:0] a;
      logic [63:0] b;
      logic        sub;
   } alu_req_type;

   typedef struct packed {
      logic [63:0] result;
      logic        carry;
   } alu_rsp_type;

endpackage

// File: hw/rtl/earliest_wakeup_task_scheduler_top.sv
// earliest-wakeup task scheduler: slot table, sequencer and result register
// end completes while idle; create walks the slots, delay and exit write a wake time and then scan every slot
// throughput: one item at a time; a new start is taken only while busy is low
// the scan is serial because of the single read port of the wake store and the one shared adder
// reset: active bits cleared, current slot 0, wake store left as is
// results appear for one cycle on rsp_valid; the receiver cannot stall
module earliest_wakeup_task_scheduler_top #(
   parameter int TASK_SLOTS = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  ewts_pkg::req_type req_item,
   output logic              rsp_valid,
   output ewts_pkg::rsp_type rsp_item
);

   // slot index width and a counter that can also hold TASK_SLOTS
   localparam int IW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
   localparam int CW = $clog2(TASK_SLOTS + 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_FIND,
      S_WRITE,
      S_SCAN,
      S_FINAL
   } state_type;

   state_type             state_ff, state_in;
   logic [TASK_SLOTS-1:0] active_ff, active_in;
   logic [IW-1:0]         cur_ff, cur_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic                  cmp_valid_ff, cmp_valid_in;
   logic [IW-1:0]         cmp_idx_ff, cmp_idx_in;
   logic                  found_ff, found_in;
   logic [IW-1:0]         best_ff, best_in;
   logic [63:0]           best_wake_ff, best_wake_in;
   logic [63:0]           now_ff, now_in;
   logic [31:0]           ticks_ff, ticks_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   ewts_pkg::rsp_type     rsp_ff, rsp_in;

   // wake store and shared unit hookup
   logic                  wr_en;
   logic [IW-1:0]         wr_addr;
   logic [63:0]           wr_data;
   logic [IW-1:0]         rd_addr;
   logic [63:0]           rd_data;
   ewts_pkg::alu_req_type alu_req;
   ewts_pkg::alu_rsp_type alu_rsp;

   logic [31:0]           idx_wide;
   logic [IW-1:0]         idx_sel;

   // reported slot is the low three bits of the table index
   function automatic logic [2:0] slot3(input logic [IW-1:0] v);
      logic [31:0] w;
      w = 32'(v);
      return w[2:0];
   endfunction

   ewts_wake_mem #(
      .DEPTH (TASK_SLOTS),
      .AW    (IW)
   ) u_wake_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   ewts_alu u_alu (
      .alu_req (alu_req),
      .alu_rsp (alu_rsp)
   );

   assign idx_wide = 32'(req_item.task_index);
   assign idx_sel  = idx_wide[IW-1:0];

   // one adder serves wake = now + ticks, the scan compare and the final wait
   always_comb begin
      case (state_ff)
         S_WRITE: begin
            alu_req.a   = now_ff;
            alu_req.b   = 64'(ticks_ff);
            alu_req.sub = 1'b0;
         end
         S_FINAL: begin
            alu_req.a   = best_wake_ff;
            alu_req.b   = now_ff;
            alu_req.sub = 1'b1;
         end
         default: begin
            alu_req.a   = rd_data;
            alu_req.b   = best_wake_ff;
            alu_req.sub = 1'b1;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      active_in    = active_ff;
      cur_in       = cur_ff;
      cnt_in       = cnt_ff;
      cmp_valid_in = cmp_valid_ff;
      cmp_idx_in   = cmp_idx_ff;
      found_in     = found_ff;
      best_in      = best_ff;
      best_wake_in = best_wake_ff;
      now_in       = now_ff;
      ticks_in     = ticks_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_addr      = cur_ff;
      wr_data      = alu_rsp.result;
      rd_addr      = cnt_ff[IW-1:0];

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               now_in = req_item.now;
               case (req_item.opcode)
                  ewts_pkg::OP_CREATE: begin
                     cnt_in   = '0;
                     state_in = S_FIND;
                  end
                  ewts_pkg::OP_END: begin
                     // slot outside the table is ignored
                     if (idx_wide < 32'(TASK_SLOTS)) begin
                        active_in[idx_sel] = 1'b0;
                     end
                     rsp_in.status   = ewts_pkg::ST_OK;
                     rsp_in.slot     = req_item.task_index;
                     rsp_in.delay_ms = '0;
                     rsp_valid_in    = 1'b1;
                  end
                  ewts_pkg::OP_DELAY: begin
                     ticks_in = req_item.sleep_ticks;
                     state_in = S_WRITE;
                  end
                  ewts_pkg::OP_EXIT: begin
                     active_in[cur_ff] = 1'b0;
                     ticks_in          = '0;
                     state_in          = S_WRITE;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end

         // walk the active bits, lowest free slot wins
         S_FIND: begin
            if (!active_ff[cnt_ff[IW-1:0]]) begin
               active_in[cnt_ff[IW-1:0]] = 1'b1;
               wr_en           = 1'b1;
               wr_addr         = cnt_ff[IW-1:0];
               wr_data         = '0;
               rsp_in.status   = ewts_pkg::ST_OK;
               rsp_in.slot     = slot3(cnt_ff[IW-1:0]);
               rsp_in.delay_ms = '0;
               rsp_valid_in    = 1'b1;
               state_in        = S_IDLE;
            end else if (32'(cnt_ff) == 32'(TASK_SLOTS - 1)) begin
               rsp_in.status   = ewts_pkg::ST_FULL;
               rsp_in.slot     = '0;
               rsp_in.delay_ms = '0;
               rsp_valid_in    = 1'b1;
               state_in        = S_IDLE;
            end else begin
               cnt_in = cnt_ff + CW'(1);
            end
         end

         // current slot's wake time is written even when it is inactive
         S_WRITE: begin
            wr_en        = 1'b1;
            wr_addr      = cur_ff;
            wr_data      = alu_rsp.result;
            cnt_in       = '0;
            cmp_valid_in = 1'b0;
            found_in     = 1'b0;
            best_in      = '0;
            best_wake_in = ewts_pkg::WAKE_MAX;
            state_in     = S_SCAN;
         end

         // read one slot per cycle, compare the one read the cycle before
         S_SCAN: begin
            if (32'(cnt_ff) < 32'(TASK_SLOTS)) begin
               cmp_valid_in = 1'b1;
               cmp_idx_in   = cnt_ff[IW-1:0];
               cnt_in       = cnt_ff + CW'(1);
            end else begin
               cmp_valid_in = 1'b0;
            end
            if (cmp_valid_ff) begin
               // strict less-than keeps the lower index on ties
               if (active_ff[cmp_idx_ff] && (!found_ff || !alu_rsp.carry)) begin
                  found_in     = 1'b1;
                  best_in      = cmp_idx_ff;
                  best_wake_in = rd_data;
               end
               if (32'(cmp_idx_ff) == 32'(TASK_SLOTS - 1)) begin
                  cmp_valid_in = 1'b0;
                  state_in     = S_FINAL;
               end
            end
         end

         // wait is best - now when best is not yet due
         S_FINAL: begin
            if (found_ff) begin
               cur_in          = best_ff;
               rsp_in.status   = ewts_pkg::ST_OK;
               rsp_in.slot     = slot3(best_ff);
               rsp_in.delay_ms = alu_rsp.carry ? alu_rsp.result[31:0] : 32'd0;
            end else begin
               rsp_in.status   = ewts_pkg::ST_NOTASK;
               rsp_in.slot     = '0;
               rsp_in.delay_ms = '0;
            end
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         active_ff    <= '0;
         cur_ff       <= '0;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         cur_ff       <= cur_in;
         cmp_valid_ff <= cmp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cnt_ff       <= cnt_in;
      cmp_idx_ff   <= cmp_idx_in;
      found_ff     <= found_in;
      best_ff      <= best_in;
      best_wake_ff <= best_wake_in;
      now_ff       <= now_in;
      ticks_ff     <= ticks_in;
      rsp_ff       <= rsp_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   a_rsp_only_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !busy)
      else $error("result strobe while sequencer busy");

   a_multi_cycle_ops_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_item.opcode != ewts_pkg::OP_END) |=> busy)
      else $error("create, delay or exit did not enter the sequencer");

   a_notask_none_active: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.status == ewts_pkg::ST_NOTASK) |-> (active_ff == '0))
      else $error("no-task status with an active slot");

   a_cur_in_table: assert property (@(posedge clock) disable iff (reset)
      32'(cur_ff) < 32'(TASK_SLOTS))
      else $error("current slot outside the table");

endmodule

// File: hw/rtl/ewts_alu.sv
// shared 64-bit add/subtract unit, carry out doubles as compare result
module ewts_alu (
   input  ewts_pkg::alu_req_type alu_req,
   output ewts_pkg::alu_rsp_type alu_rsp
);

   logic [64:0] sum;
   logic [63:0] b_op;

   // subtract as a + ~b + 1, carry set means a >= b
   assign b_op = alu_req.sub ? ~alu_req.b : alu_req.b;
   assign sum  = {1'b0, alu_req.a} + {1'b0, b_op} + 65'(alu_req.sub);

   assign alu_rsp.result = sum[63:0];
   assign alu_rsp.carry  = sum[64];

endmodule

// File: hw/rtl/ewts_wake_mem.sv
// wake time store, one write and one registered read port
module ewts_wake_mem #(
   parameter int DEPTH = 8,
   parameter int AW    = 3
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [63:0]   wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [63:0]   rd_data
);

   logic [63:0] mem [DEPTH];
   logic [63:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
